>>> hdl/rlbfs_pkg.sv
// ----------------------------------------------------------------------------
// rlbfs_pkg
// Shared types and constants for the RGB LED blink and fade sequencer.
// ----------------------------------------------------------------------------
package rlbfs_pkg;

    // default widths of levels and of the step period
    localparam int LEVEL_WIDTH_DEF  = 8;
    localparam int PERIOD_WIDTH_DEF = 16;

    // register map
    localparam int CFG_ADDR_WIDTH = 3;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_WORK_MODE   = 3'd0,
        REG_STEP_PERIOD = 3'd1,
        REG_RED_MAX     = 3'd2,
        REG_GREEN_MAX   = 3'd3,
        REG_BLUE_MAX    = 3'd4
    } cfg_reg_t;

    // operating modes
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STEADY = 2'd1,
        MODE_BLINK  = 2'd2,
        MODE_FADE   = 2'd3
    } work_mode_t;

    localparam int MODE_WIDTH = 2;

    // reset values
    localparam work_mode_t WORK_MODE_RESET  = MODE_BLINK;
    localparam int         STEP_PERIOD_RESET = 1000;

    // control from the register block to the step engine
    typedef struct packed {
        work_mode_t mode;
        logic       reload;
    } cfg_ctrl_t;

endpackage

>>> hdl/rlbfs_cfg.sv
// ----------------------------------------------------------------------------
// rlbfs_cfg
// Configuration registers: mode, step period and the three target levels.
// ----------------------------------------------------------------------------
module rlbfs_cfg
    import rlbfs_pkg::*;
#(
    parameter int LEVEL_WIDTH    = LEVEL_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = PERIOD_WIDTH_DEF,
    parameter int CFG_DATA_WIDTH = PERIOD_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    output cfg_ctrl_t                 ctrl,
    output logic [PERIOD_WIDTH-1:0]   step_period,
    output logic [LEVEL_WIDTH-1:0]    red_max,
    output logic [LEVEL_WIDTH-1:0]    green_max,
    output logic [LEVEL_WIDTH-1:0]    blue_max,
    output logic [LEVEL_WIDTH-1:0]    red_load,
    output logic [LEVEL_WIDTH-1:0]    green_load,
    output logic [LEVEL_WIDTH-1:0]    blue_load
);

    work_mode_t              mode_reg, mode_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic [LEVEL_WIDTH-1:0]  red_max_reg, red_max_next;
    logic [LEVEL_WIDTH-1:0]  green_max_reg, green_max_next;
    logic [LEVEL_WIDTH-1:0]  blue_max_reg, blue_max_next;
    logic                    reload;
    logic [PERIOD_WIDTH-1:0] wr_period;
    logic [LEVEL_WIDTH-1:0]  wr_level;

    assign wr_period = cfg_wdata[PERIOD_WIDTH-1:0];
    assign wr_level  = cfg_wdata[LEVEL_WIDTH-1:0];

    // register write decode, zero period writes are dropped
    always_comb begin
        mode_next      = mode_reg;
        period_next    = period_reg;
        red_max_next   = red_max_reg;
        green_max_next = green_max_reg;
        blue_max_next  = blue_max_reg;
        reload         = 1'b0;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_WORK_MODE: begin
                    mode_next = work_mode_t'(cfg_wdata[MODE_WIDTH-1:0]);
                    reload    = 1'b1;
                end
                REG_STEP_PERIOD: begin
                    if (wr_period != '0) begin
                        period_next = wr_period;
                        reload      = 1'b1;
                    end
                end
                REG_RED_MAX: begin
                    red_max_next = wr_level;
                    reload       = 1'b1;
                end
                REG_GREEN_MAX: begin
                    green_max_next = wr_level;
                    reload         = 1'b1;
                end
                REG_BLUE_MAX: begin
                    blue_max_next = wr_level;
                    reload        = 1'b1;
                end
                default: begin
                    reload = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= WORK_MODE_RESET;
            period_reg    <= PERIOD_WIDTH'(STEP_PERIOD_RESET);
            red_max_reg   <= '0;
            green_max_reg <= '0;
            blue_max_reg  <= '0;
        end else begin
            mode_reg      <= mode_next;
            period_reg    <= period_next;
            red_max_reg   <= red_max_next;
            green_max_reg <= green_max_next;
            blue_max_reg  <= blue_max_next;
        end
    end

    assign ctrl.mode   = mode_reg;
    assign ctrl.reload = reload;
    assign step_period = period_reg;
    assign red_max     = red_max_reg;
    assign green_max   = green_max_reg;
    assign blue_max    = blue_max_reg;

    // levels reload from the maxima as they stand after the write
    assign red_load   = red_max_next;
    assign green_load = green_max_next;
    assign blue_load  = blue_max_next;

endmodule

>>> hdl/rlbfs_step.sv
// ----------------------------------------------------------------------------
// rlbfs_step
// Tick counter, blink/fade step logic and the result register.
// ----------------------------------------------------------------------------
module rlbfs_step
    import rlbfs_pkg::*;
#(
    parameter int LEVEL_WIDTH  = LEVEL_WIDTH_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_ctrl_t               ctrl,
    input  logic [PERIOD_WIDTH-1:0] step_period,
    input  logic [LEVEL_WIDTH-1:0]  red_max,
    input  logic [LEVEL_WIDTH-1:0]  green_max,
    input  logic [LEVEL_WIDTH-1:0]  blue_max,
    input  logic [LEVEL_WIDTH-1:0]  red_load,
    input  logic [LEVEL_WIDTH-1:0]  green_load,
    input  logic [LEVEL_WIDTH-1:0]  blue_load,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_tick,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [LEVEL_WIDTH-1:0]  m_red_level,
    output logic [LEVEL_WIDTH-1:0]  m_green_level,
    output logic [LEVEL_WIDTH-1:0]  m_blue_level,
    output logic                    m_red_enable,
    output logic                    m_green_enable,
    output logic                    m_blue_enable,
    output logic                    m_phase_on
);

    // sequencer state
    logic [PERIOD_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic                    phase_reg, phase_next;
    logic [LEVEL_WIDTH-1:0]  red_reg, red_next;
    logic [LEVEL_WIDTH-1:0]  green_reg, green_next;
    logic [LEVEL_WIDTH-1:0]  blue_reg, blue_next;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [LEVEL_WIDTH-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic                   out_red_en_reg, out_green_en_reg, out_blue_en_reg;
    logic                   out_phase_reg;

    logic                    accept;
    logic [PERIOD_WIDTH-1:0] count;
    logic                    fire;
    logic [LEVEL_WIDTH-1:0]  red_step, green_step, blue_step;
    logic                    phase_step;
    logic                    allow;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // saturating tick count and step trigger
    always_comb begin
        count = elapsed_reg;
        if (s_tick && (elapsed_reg < step_period)) begin
            count = elapsed_reg + PERIOD_WIDTH'(1);
        end
        fire = ((ctrl.mode == MODE_BLINK) || (ctrl.mode == MODE_FADE))
               && (count >= step_period);
    end

    // one blink toggle or one fade step
    always_comb begin
        red_step   = red_reg;
        green_step = green_reg;
        blue_step  = blue_reg;
        phase_step = phase_reg;
        if (fire) begin
            if (ctrl.mode == MODE_BLINK) begin
                phase_step = !phase_reg;
            end else if (!phase_reg) begin
                if (red_reg != '0) red_step = red_reg - LEVEL_WIDTH'(1);
                if (green_reg != '0) green_step = green_reg - LEVEL_WIDTH'(1);
                if (blue_reg != '0) blue_step = blue_reg - LEVEL_WIDTH'(1);
                if ((red_step == '0) && (green_step == '0) && (blue_step == '0)) begin
                    phase_step = 1'b1;
                end
            end else begin
                if (red_reg < red_max) red_step = red_reg + LEVEL_WIDTH'(1);
                if (green_reg < green_max) green_step = green_reg + LEVEL_WIDTH'(1);
                if (blue_reg < blue_max) blue_step = blue_reg + LEVEL_WIDTH'(1);
                if ((red_step == red_max) && (green_step == green_max)
                    && (blue_step == blue_max)) begin
                    phase_step = 1'b0;
                end
            end
        end
    end

    // channel gating by mode and phase
    always_comb begin
        case (ctrl.mode)
            MODE_OFF:    allow = 1'b0;
            MODE_BLINK:  allow = phase_step;
            MODE_STEADY: allow = 1'b1;
            MODE_FADE:   allow = 1'b1;
            default:     allow = 1'b0;
        endcase
    end

    // state update: a request advances; a register write reloads levels only when no request is taken
    always_comb begin
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        if (accept) begin
            elapsed_next = fire ? '0 : count;
            phase_next   = phase_step;
            red_next     = red_step;
            green_next   = green_step;
            blue_next    = blue_step;
        end else if (ctrl.reload) begin
            red_next   = red_load;
            green_next = green_load;
            blue_next  = blue_load;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            phase_reg     <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            out_red_reg      <= red_step;
            out_green_reg    <= green_step;
            out_blue_reg     <= blue_step;
            out_red_en_reg   <= allow && (red_step != '0);
            out_green_en_reg <= allow && (green_step != '0);
            out_blue_en_reg  <= allow && (blue_step != '0);
            out_phase_reg    <= phase_step;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red_level    = out_red_reg;
    assign m_green_level  = out_green_reg;
    assign m_blue_level   = out_blue_reg;
    assign m_red_enable   = out_red_en_reg;
    assign m_green_enable = out_green_en_reg;
    assign m_blue_enable  = out_blue_en_reg;
    assign m_phase_on     = out_phase_reg;

endmodule

>>> hdl/rgb_led_blink_fade_sequencer_top.sv
// ----------------------------------------------------------------------------
// rgb_led_blink_fade_sequencer_top
// Blink and breathing-fade sequencer for one RGB LED, driven by timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel carries one tick flag. Every request
//   produces exactly one result on the m_ channel: the three current levels,
//   the three channel enables and the blink/fade phase.
//   The result of a request is registered and shows from the cycle after it
//   is taken. Throughput is one request per cycle while m_ready stays high;
//   the limit is the update loop of the tick counter and level registers.
//   A held result does not block the input while the receiver takes it in
//   the same cycle; when m_ready is low with a result waiting, s_ready drops
//   and the block holds its state and result.
//   Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
//   write them only while no request is in flight, the block does not enforce
//   it; each accepted write reloads the current levels from the maxima.
//   Synchronous reset (aresetn low) selects blink mode, a period of 1000
//   ticks, zero levels and maxima, the off phase, and empties the result
//   register.
// ----------------------------------------------------------------------------
module rgb_led_blink_fade_sequencer_top
    import rlbfs_pkg::*;
#(
    parameter int LEVEL_WIDTH  = LEVEL_WIDTH_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF,
    localparam int CFG_DATA_WIDTH = (PERIOD_WIDTH > LEVEL_WIDTH) ? PERIOD_WIDTH : LEVEL_WIDTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_tick,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [LEVEL_WIDTH-1:0]    m_red_level,
    output logic [LEVEL_WIDTH-1:0]    m_green_level,
    output logic [LEVEL_WIDTH-1:0]    m_blue_level,
    output logic                      m_red_enable,
    output logic                      m_green_enable,
    output logic                      m_blue_enable,
    output logic                      m_phase_on
);

    cfg_ctrl_t               ctrl;
    logic [PERIOD_WIDTH-1:0] step_period;
    logic [LEVEL_WIDTH-1:0]  red_max, green_max, blue_max;
    logic [LEVEL_WIDTH-1:0]  red_load, green_load, blue_load;

    // configuration registers
    rlbfs_cfg #(
        .LEVEL_WIDTH    (LEVEL_WIDTH),
        .PERIOD_WIDTH   (PERIOD_WIDTH),
        .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .ctrl        (ctrl),
        .step_period (step_period),
        .red_max     (red_max),
        .green_max   (green_max),
        .blue_max    (blue_max),
        .red_load    (red_load),
        .green_load  (green_load),
        .blue_load   (blue_load)
    );

    // step engine and result register
    rlbfs_step #(
        .LEVEL_WIDTH  (LEVEL_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_step (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .step_period    (step_period),
        .red_max        (red_max),
        .green_max      (green_max),
        .blue_max       (blue_max),
        .red_load       (red_load),
        .green_load     (green_load),
        .blue_load      (blue_load),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_level    (m_red_level),
        .m_green_level  (m_green_level),
        .m_blue_level   (m_blue_level),
        .m_red_enable   (m_red_enable),
        .m_green_enable (m_green_enable),
        .m_blue_enable  (m_blue_enable),
        .m_phase_on     (m_phase_on)
    );

endmodule

>>> hdl/rlbfs_checker.sv
// ----------------------------------------------------------------------------
// rlbfs_assertions
// Port-level checks for the sequencer top level, attached by bind.
// ----------------------------------------------------------------------------
module rlbfs_assertions
    import rlbfs_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [LEVEL_WIDTH-1:0] m_red_level,
    input logic [LEVEL_WIDTH-1:0] m_green_level,
    input logic [LEVEL_WIDTH-1:0] m_blue_level,
    input logic                   m_red_enable,
    input logic                   m_green_enable,
    input logic                   m_blue_enable
);

    // result register empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted request always yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("request accepted without a result");

    // input is taken whenever the result register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with result register free");

    // an enabled channel never has a zero level
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_red_enable || (m_red_level != '0))
                     && (!m_green_enable || (m_green_level != '0))
                     && (!m_blue_enable || (m_blue_level != '0))))
        else $error("channel enabled at zero level");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red_level)
                                   && $stable(m_green_level) && $stable(m_blue_level)))
        else $error("stalled result changed");

endmodule

bind rgb_led_blink_fade_sequencer_top rlbfs_assertions #(
    .LEVEL_WIDTH (LEVEL_WIDTH)
) u_rlbfs_assertions (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_red_level    (m_red_level),
    .m_green_level  (m_green_level),
    .m_blue_level   (m_blue_level),
    .m_red_enable   (m_red_enable),
    .m_green_enable (m_green_enable),
    .m_blue_enable  (m_blue_enable)
);

>>> sim/rlbfs_checker.sv
// ----------------------------------------------------------------------------
// rlbfs_checker
// Watches the register port and the request and result channels of the RGB LED
// sequencer, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module rlbfs_checker
    import rlbfs_pkg::*;
#(
    parameter int LEVEL_WIDTH    = LEVEL_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = PERIOD_WIDTH_DEF,
    parameter int CFG_DATA_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_tick,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [LEVEL_WIDTH-1:0]    m_red_level,
    input  logic [LEVEL_WIDTH-1:0]    m_green_level,
    input  logic [LEVEL_WIDTH-1:0]    m_blue_level,
    input  logic                      m_red_enable,
    input  logic                      m_green_enable,
    input  logic                      m_blue_enable,
    input  logic                      m_phase_on,
    output int                        fail_count,
    output int                        pending
);

    // one predicted led frame
    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] red;
        logic [LEVEL_WIDTH-1:0] green;
        logic [LEVEL_WIDTH-1:0] blue;
        logic                   red_on;
        logic                   green_on;
        logic                   blue_on;
        logic                   phase_on;
    } led_frame_t;

    led_frame_t frames_due[$];
    led_frame_t want;
    int         errors = 0;

    // predicted registers and sequencer state
    work_mode_t              mode_q;
    logic [PERIOD_WIDTH-1:0] period_q;
    logic [PERIOD_WIDTH-1:0] ticks_q;
    logic [LEVEL_WIDTH-1:0]  red_max, green_max, blue_max;
    logic [LEVEL_WIDTH-1:0]  red_now, green_now, blue_now;
    logic                    phase_q;

    // register write: every accepted write reloads the levels from the maxima
    task automatic write_register(input logic [CFG_ADDR_WIDTH-1:0] addr,
                                  input logic [CFG_DATA_WIDTH-1:0] data);
        case (addr)
            REG_WORK_MODE: begin
                mode_q = work_mode_t'(data[MODE_WIDTH-1:0]);
            end
            REG_STEP_PERIOD: begin
                // a zero period is dropped without a reload
                if (data[PERIOD_WIDTH-1:0] == '0) return;
                period_q = data[PERIOD_WIDTH-1:0];
            end
            REG_RED_MAX:   red_max   = data[LEVEL_WIDTH-1:0];
            REG_GREEN_MAX: green_max = data[LEVEL_WIDTH-1:0];
            REG_BLUE_MAX:  blue_max  = data[LEVEL_WIDTH-1:0];
            default: return;
        endcase
        red_now   = red_max;
        green_now = green_max;
        blue_now  = blue_max;
    endtask

    // one tick request: count, maybe step, then build the frame
    task automatic advance_led(input logic tick);
        led_frame_t f;
        logic       lit;
        if (tick && ticks_q < period_q) ticks_q = ticks_q + PERIOD_WIDTH'(1);
        if ((mode_q == MODE_BLINK || mode_q == MODE_FADE) && ticks_q >= period_q) begin
            ticks_q = '0;
            if (mode_q == MODE_BLINK) begin
                phase_q = ~phase_q;
            end else if (!phase_q) begin
                // falling: walk every lit channel toward zero
                if (red_now != '0)   red_now   = red_now - LEVEL_WIDTH'(1);
                if (green_now != '0) green_now = green_now - LEVEL_WIDTH'(1);
                if (blue_now != '0)  blue_now  = blue_now - LEVEL_WIDTH'(1);
                if (red_now == '0 && green_now == '0 && blue_now == '0) phase_q = 1'b1;
            end else begin
                // rising: walk every channel back up to its maximum
                if (red_now < red_max)     red_now   = red_now + LEVEL_WIDTH'(1);
                if (green_now < green_max) green_now = green_now + LEVEL_WIDTH'(1);
                if (blue_now < blue_max)   blue_now  = blue_now + LEVEL_WIDTH'(1);
                if (red_now == red_max && green_now == green_max && blue_now == blue_max)
                    phase_q = 1'b0;
            end
        end
        lit = (mode_q == MODE_STEADY) || (mode_q == MODE_FADE)
            || (mode_q == MODE_BLINK && phase_q);
        f.red      = red_now;
        f.green    = green_now;
        f.blue     = blue_now;
        f.red_on   = lit && (red_now != '0);
        f.green_on = lit && (green_now != '0);
        f.blue_on  = lit && (blue_now != '0);
        f.phase_on = phase_q;
        frames_due.push_back(f);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // compare before predicting: a result leaving now belongs to an older request
    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_q    = WORK_MODE_RESET;
            period_q  = PERIOD_WIDTH'(STEP_PERIOD_RESET);
            ticks_q   = '0;
            red_max   = '0;
            green_max = '0;
            blue_max  = '0;
            red_now   = '0;
            green_now = '0;
            blue_now  = '0;
            phase_q   = 1'b0;
            frames_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (frames_due.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = frames_due.pop_front();
                    check_field("red_level",    32'(want.red),      32'(m_red_level));
                    check_field("green_level",  32'(want.green),    32'(m_green_level));
                    check_field("blue_level",   32'(want.blue),     32'(m_blue_level));
                    check_field("red_enable",   32'(want.red_on),   32'(m_red_enable));
                    check_field("green_enable", 32'(want.green_on), 32'(m_green_enable));
                    check_field("blue_enable",  32'(want.blue_on),  32'(m_blue_enable));
                    check_field("phase_on",     32'(want.phase_on), 32'(m_phase_on));
                end
            end
            if (cfg_we) write_register(cfg_addr, cfg_wdata);
            if (s_valid && s_ready) advance_led(s_tick);
        end
        pending    <= frames_due.size();
        fail_count <= errors;
    end

endmodule

>>> sim/rgb_led_blink_fade_sequencer_top_tb.sv
// ----------------------------------------------------------------------------
// rgb_led_blink_fade_sequencer_top_tb
// Drives tick requests and register writes into the sequencer under several
// idle and stall patterns; the checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module rgb_led_blink_fade_sequencer_top_tb;
    import rlbfs_pkg::*;

    localparam int LEVEL_WIDTH    = LEVEL_WIDTH_DEF;
    localparam int PERIOD_WIDTH   = PERIOD_WIDTH_DEF;
    localparam int CFG_DATA_WIDTH = (PERIOD_WIDTH > LEVEL_WIDTH) ? PERIOD_WIDTH : LEVEL_WIDTH;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RANDOM_TICKS   = 700;

    // first register index past the end of the map, and the last index of the port
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_PAST_END = REG_BLUE_MAX + 1'b1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LAST_IDX = '1;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_tick = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [LEVEL_WIDTH-1:0]    m_red_level, m_green_level, m_blue_level;
    logic                      m_red_enable, m_green_enable, m_blue_enable;
    logic                      m_phase_on;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;

    rgb_led_blink_fade_sequencer_top #(
        .LEVEL_WIDTH  (LEVEL_WIDTH),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_level    (m_red_level),
        .m_green_level  (m_green_level),
        .m_blue_level   (m_blue_level),
        .m_red_enable   (m_red_enable),
        .m_green_enable (m_green_enable),
        .m_blue_enable  (m_blue_enable),
        .m_phase_on     (m_phase_on)
    );

    rlbfs_checker #(
        .LEVEL_WIDTH    (LEVEL_WIDTH),
        .PERIOD_WIDTH   (PERIOD_WIDTH),
        .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick         (s_tick),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_level    (m_red_level),
        .m_green_level  (m_green_level),
        .m_blue_level   (m_blue_level),
        .m_red_enable   (m_red_enable),
        .m_green_enable (m_green_enable),
        .m_blue_enable  (m_blue_enable),
        .m_phase_on     (m_phase_on),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("rgb_led_blink_fade_sequencer_top: mismatch");
            $finish;
        end
    end

    // one register write, then release the enable
    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] addr,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // wait until every predicted frame has been taken
    task automatic drain_frames();
        do @(posedge aclk); while (pending != 0);
    endtask

    // drain, then let the pipeline settle before touching registers
    task automatic wait_idle();
        drain_frames();
        repeat (2) @(posedge aclk);
    endtask

    // send tick requests with random sender gaps
    task automatic run_ticks(input int count, input int tick_pct);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end else begin
                s_valid <= 1'b1;
                s_tick  <= ($urandom_range(99) < tick_pct);
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                sent++;
            end
        end
        s_valid <= 1'b0;
    endtask

    // random level write, upper data bits random as well
    function automatic logic [CFG_DATA_WIDTH-1:0] pick_level();
        logic [CFG_DATA_WIDTH-1:0] data;
        data = CFG_DATA_WIDTH'($urandom_range(65535));
        if ($urandom_range(1) == 0)
            data = (data & ~CFG_DATA_WIDTH'((1 << LEVEL_WIDTH) - 1))
                 | CFG_DATA_WIDTH'($urandom_range(4));
        return data;
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return CFG_DATA_WIDTH'($urandom_range(1, 6));
        if (roll < 85) return CFG_DATA_WIDTH'($urandom_range(7, 300));
        if (roll < 90) return '0;
        if (roll < 95) return '1;
        return CFG_DATA_WIDTH'($urandom_range(65535));
    endfunction

    function automatic work_mode_t pick_mode();
        case ($urandom_range(9))
            0:       return MODE_OFF;
            1:       return MODE_STEADY;
            2, 3, 4: return MODE_BLINK;
            default: return MODE_FADE;
        endcase
    endfunction

    // new random settings; some registers are left as they were
    task automatic shuffle_settings();
        if ($urandom_range(99) < 70) write_reg(REG_STEP_PERIOD, pick_period());
        if ($urandom_range(99) < 70) write_reg(REG_RED_MAX, pick_level());
        if ($urandom_range(99) < 70) write_reg(REG_GREEN_MAX, pick_level());
        if ($urandom_range(99) < 70) write_reg(REG_BLUE_MAX, pick_level());
        if ($urandom_range(99) < 10)
            write_reg(CFG_ADDR_WIDTH'($urandom_range(REG_PAST_END, REG_LAST_IDX)),
                      CFG_DATA_WIDTH'($urandom_range(65535)));
        if ($urandom_range(99) < 80) write_reg(REG_WORK_MODE, CFG_DATA_WIDTH'(pick_mode()));
    endtask

    initial begin
        int total;
        int burst;
        int tick_pct;
        int phase_idx;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: blink with a long period, every level zero
        run_ticks(1, 100);
        run_ticks(1, 0);

        // off mode: counter saturates while nothing is lit
        wait_idle();
        write_reg(REG_WORK_MODE, CFG_DATA_WIDTH'(MODE_OFF));
        write_reg(REG_STEP_PERIOD, CFG_DATA_WIDTH'(2));
        write_reg(REG_RED_MAX, '1);
        write_reg(REG_GREEN_MAX, '0);
        write_reg(REG_BLUE_MAX, CFG_DATA_WIDTH'(1));
        run_ticks(3, 100);

        // blink entry with a saturated counter steps at once, even with no tick
        wait_idle();
        write_reg(REG_WORK_MODE, CFG_DATA_WIDTH'(MODE_BLINK));
        run_ticks(1, 0);

        // steady on lights every nonzero channel whatever the phase
        wait_idle();
        write_reg(REG_WORK_MODE, CFG_DATA_WIDTH'(MODE_STEADY));
        run_ticks(1, 0);

        // fade one step per tick, moving the levels off their maxima
        wait_idle();
        write_reg(REG_STEP_PERIOD, CFG_DATA_WIDTH'(1));
        write_reg(REG_WORK_MODE, CFG_DATA_WIDTH'(MODE_FADE));
        run_ticks(3, 100);

        // zero period and an unused index change nothing, levels not reloaded
        wait_idle();
        write_reg(REG_STEP_PERIOD, '0);
        run_ticks(1, 100);
        wait_idle();
        write_reg(REG_PAST_END, '1);
        run_ticks(1, 100);

        // longest period
        wait_idle();
        write_reg(REG_STEP_PERIOD, '1);
        run_ticks(1, 100);

        // short fade through both turning points
        wait_idle();
        write_reg(REG_STEP_PERIOD, CFG_DATA_WIDTH'(1));
        write_reg(REG_RED_MAX, CFG_DATA_WIDTH'(2));
        write_reg(REG_GREEN_MAX, CFG_DATA_WIDTH'(1));
        write_reg(REG_BLUE_MAX, '0);
        run_ticks(8, 100);

        // random phases under rotating idle and stall patterns
        total = 0;
        phase_idx = 0;
        while (total < RANDOM_TICKS) begin
            wait_idle();
            shuffle_settings();
            case (phase_idx % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            case ($urandom_range(2))
                0:       tick_pct = 100;
                1:       tick_pct = 60;
                default: tick_pct = 15;
            endcase
            burst = $urandom_range(15, 35);
            if (phase_idx % 7 == 3) begin
                // hold the sender until every frame is out, then go on
                run_ticks(burst / 2, tick_pct);
                drain_frames();
                run_ticks(burst - burst / 2, tick_pct);
            end else begin
                run_ticks(burst, tick_pct);
            end
            total += burst;
            phase_idx++;
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("rgb_led_blink_fade_sequencer_top: match");
        end else begin
            $display("rgb_led_blink_fade_sequencer_top: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/rlbfs_pkg.sv
hdl/rlbfs_cfg.sv
hdl/rlbfs_step.sv
hdl/rgb_led_blink_fade_sequencer_top.sv
hdl/rlbfs_checker.sv
sim/rlbfs_checker.sv
sim/rgb_led_blink_fade_sequencer_top_tb.sv
